FILE: rtl/core/idll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idll_pkg
// Shared widths, command codes and controller/datapath signal groups for the
// indexed doubly linked list.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd3;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic clear;
    logic take;
    logic cap_node;
    logic exec_res;
    logic wr_node;
    logic wr_unlink;
    logic wr_link;
    logic load_rsp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic ins_ok;
    logic del_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/idll_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idll_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
interface idll_cmd_if import idll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] anchor;

  modport source (output valid, output command, output node, output anchor, input ready);
  modport sink (input valid, input command, input node, input anchor, output ready);
endinterface

interface idll_rsp_if import idll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] prev_node;
  logic              node_present;

  modport source (output valid, output status, output next_node, output prev_node,
                  output node_present, input ready);
  modport sink (input valid, input status, input next_node, input prev_node,
                input node_present, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/indexed_doubly_linked_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// Circular doubly linked list of node numbers with node 0 as the head.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat. After acceptance the
// node's links are read, then the anchor's links, then the command executes
// into the result register; a successful insert adds a link-write step
// before the result is loaded. The steps are set by the single-port next,
// prev and presence stores, which see one node read, one anchor read and up
// to two writes per command. One command is in flight at a time; the next
// is taken in the cycle its predecessor's result is loaded. After reset a
// clearing pass sweeps all 1024 entries; no command is taken until it ends.
module indexed_doubly_linked_list_top import idll_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  idll_cmd_if.sink   cmd_i,
  idll_rsp_if.source rsp_o
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  idll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  idll_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .command_i      (cmd_i.command),
    .node_i         (cmd_i.node),
    .anchor_i       (cmd_i.anchor),
    .status_o       (rsp_o.status),
    .next_node_o    (rsp_o.next_node),
    .prev_node_o    (rsp_o.prev_node),
    .node_present_o (rsp_o.node_present)
  );

endmodule
`default_nettype wire

FILE: rtl/core/idll_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idll_ctrl
// Command sequencer: clearing sweep, link reads, link writes, result beat.
// ----------------------------------------------------------------------------
module idll_ctrl import idll_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      ctl_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDN   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;
  logic       take;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
  assign take        = cmd_ready_o && cmd_valid_i;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.take = take;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clear = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) state_d = S_RDN;
      end
      S_RDN: begin
        ctl_o.cap_node = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        ctl_o.exec_res  = 1'b1;
        ctl_o.wr_node   = stat_i.ins_ok;
        ctl_o.wr_unlink = stat_i.del_ok;
        state_d = stat_i.ins_ok ? S_LINK : S_RESP;
      end
      S_LINK: begin
        ctl_o.wr_link = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ctl_o.load_rsp = 1'b1;
          state_d = take ? S_RDN : S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (ctl_o.load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/idll_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idll_dpath
// Link and presence stores, command and read registers, result register.
// ----------------------------------------------------------------------------
module idll_dpath import idll_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         ctl_i,
  output dp_stat_t               stat_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [NODE_W-1:0] node_i,
  input  wire logic [NODE_W-1:0] anchor_i,
  output logic                   status_o,
  output logic [NODE_W-1:0]      next_node_o,
  output logic [NODE_W-1:0]      prev_node_o,
  output logic                   node_present_o
);

  logic [NODE_W-1:0] next_mem [NODE_COUNT];
  logic [NODE_W-1:0] prev_mem [NODE_COUNT];
  logic              in_mem   [NODE_COUNT];

  logic [NODE_W-1:0] sweep_q;
  logic [CMD_W-1:0]  command_q;
  logic [NODE_W-1:0] node_q, anchor_q;
  logic [NODE_W-1:0] rd_next_q, rd_prev_q;
  logic              rd_in_q;
  logic [NODE_W-1:0] nd_next_q, nd_prev_q;
  logic              nd_in_q;
  logic [NODE_W-1:0] bef_q, aft_q;
  logic              res_status_q, res_present_q;
  logic [NODE_W-1:0] res_next_q, res_prev_q;
  logic              out_status_q, out_present_q;
  logic [NODE_W-1:0] out_next_q, out_prev_q;

  logic              node_zero, anc_zero, nd_pres, an_pres, is_ins;
  logic [NODE_W-1:0] before_w, after_w;
  logic              res_status_d, res_present_d;
  logic [NODE_W-1:0] res_next_d, res_prev_d;

  logic              next_we, prev_we, in_we;
  logic [NODE_W-1:0] next_addr, prev_addr, in_addr, rd_addr;
  logic [NODE_W-1:0] next_wd, prev_wd;
  logic              in_wd;

  assign node_zero = (node_q == '0);
  assign anc_zero  = (anchor_q == '0);
  assign nd_pres   = node_zero || nd_in_q;
  assign an_pres   = anc_zero || rd_in_q;
  assign is_ins    = (command_q == CMD_INS_AFTER) || (command_q == CMD_INS_BEFORE);

  assign stat_o.sweep_last = (sweep_q == NODE_W'(NODE_COUNT - 1));
  assign stat_o.ins_ok     = is_ins && !node_zero && !nd_in_q && an_pres;
  assign stat_o.del_ok     = (command_q == CMD_DELETE) && !node_zero && nd_in_q;

  always_comb begin
    case (command_q)
      CMD_INS_AFTER: begin
        before_w = anchor_q;
        after_w  = rd_next_q;
      end
      CMD_INS_BEFORE: begin
        before_w = rd_prev_q;
        after_w  = anchor_q;
      end
      default: begin
        before_w = nd_prev_q;
        after_w  = nd_next_q;
      end
    endcase
  end

  always_comb begin
    if (stat_o.ins_ok) begin
      res_status_d  = STATUS_DONE;
      res_next_d    = after_w;
      res_prev_d    = before_w;
      res_present_d = 1'b1;
    end else if (stat_o.del_ok) begin
      res_status_d  = STATUS_DONE;
      res_next_d    = '0;
      res_prev_d    = '0;
      res_present_d = 1'b0;
    end else begin
      res_status_d  = (command_q == CMD_READ) ? STATUS_DONE : STATUS_REJECT;
      res_next_d    = nd_pres ? nd_next_q : '0;
      res_prev_d    = nd_pres ? nd_prev_q : '0;
      res_present_d = nd_pres;
    end
  end

  assign rd_addr = ctl_i.take ? node_i : anchor_q;

  always_comb begin
    next_we   = ctl_i.clear || ctl_i.wr_node || ctl_i.wr_unlink || ctl_i.wr_link;
    prev_we   = next_we;
    in_we     = ctl_i.clear || ctl_i.wr_node || ctl_i.wr_unlink;
    next_addr = rd_addr;
    prev_addr = rd_addr;
    in_addr   = rd_addr;
    next_wd   = '0;
    prev_wd   = '0;
    in_wd     = 1'b0;
    if (ctl_i.clear) begin
      next_addr = sweep_q;
      prev_addr = sweep_q;
      in_addr   = sweep_q;
    end else if (ctl_i.wr_node) begin
      next_addr = node_q;
      next_wd   = after_w;
      prev_addr = node_q;
      prev_wd   = before_w;
      in_addr   = node_q;
      in_wd     = 1'b1;
    end else if (ctl_i.wr_unlink) begin
      next_addr = before_w;
      next_wd   = after_w;
      prev_addr = after_w;
      prev_wd   = before_w;
      in_addr   = node_q;
    end else if (ctl_i.wr_link) begin
      next_addr = bef_q;
      next_wd   = node_q;
      prev_addr = aft_q;
      prev_wd   = node_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_addr] <= next_wd;
    rd_next_q <= next_mem[next_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_addr] <= prev_wd;
    rd_prev_q <= prev_mem[prev_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_we) in_mem[in_addr] <= in_wd;
    rd_in_q <= in_mem[in_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctl_i.clear) begin
      sweep_q <= sweep_q + NODE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      command_q <= command_i;
      node_q    <= node_i;
      anchor_q  <= anchor_i;
    end
    if (ctl_i.cap_node) begin
      nd_next_q <= rd_next_q;
      nd_prev_q <= rd_prev_q;
      nd_in_q   <= rd_in_q;
    end
    if (ctl_i.exec_res) begin
      bef_q         <= before_w;
      aft_q         <= after_w;
      res_status_q  <= res_status_d;
      res_next_q    <= res_next_d;
      res_prev_q    <= res_prev_d;
      res_present_q <= res_present_d;
    end
    if (ctl_i.load_rsp) begin
      out_status_q  <= res_status_q;
      out_next_q    <= res_next_q;
      out_prev_q    <= res_prev_q;
      out_present_q <= res_present_q;
    end
  end

  assign status_o       = out_status_q;
  assign next_node_o    = out_next_q;
  assign prev_node_o    = out_prev_q;
  assign node_present_o = out_present_q;

endmodule
`default_nettype wire

FILE: rtl/core/idll_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idll_checker
// Port-level checks on the list block, bound to the top level.
// ----------------------------------------------------------------------------
module idll_checker import idll_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cmd_valid_i,
  input wire logic              cmd_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic              status_i,
  input wire logic [NODE_W-1:0] next_node_i,
  input wire logic [NODE_W-1:0] prev_node_i,
  input wire logic              node_present_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(next_node_i) && $stable(prev_node_i) && $stable(node_present_i))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while another is in flight");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !cmd_ready_i)
    else $error("command taken before the clearing pass");

  a_absent_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !node_present_i |-> next_node_i == '0 && prev_node_i == '0)
    else $error("absent node reported with links");

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .next_node_i    (rsp_o.next_node),
  .prev_node_i    (rsp_o.prev_node),
  .node_present_i (rsp_o.node_present)
);
`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed doubly linked list. A behavioral copy
// of the link stores predicts status, links and presence for every accepted
// command beat; each result beat is checked against the oldest prediction.
// Directed tests cover the empty list, both inserts, deletes and every reject
// case. Random traffic then runs mostly valid list edits with some noise,
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import idll_pkg::*;

  typedef struct packed {
    logic              status;
    logic [NODE_W-1:0] next_node;
    logic [NODE_W-1:0] prev_node;
    logic              node_present;
  } link_rsp_t;

  logic clk;
  logic rst_n;

  idll_cmd_if cmd_bus ();
  idll_rsp_if rsp_bus ();

  indexed_doubly_linked_list_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  logic [NODE_W-1:0] succ_tbl [NODE_COUNT];
  logic [NODE_W-1:0] pred_tbl [NODE_COUNT];
  bit                member   [NODE_COUNT];
  int unsigned       live_nodes [$];
  link_rsp_t         pending_rsp [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_rsp.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit is_linked(input logic [NODE_W-1:0] n);
    return (n == '0) || member[n];
  endfunction

  task automatic model_command(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                               input logic [NODE_W-1:0] anchor, output link_rsp_t rsp);
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    rsp.status = STATUS_REJECT;
    case (cmd)
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (node != '0 && !is_linked(node) && is_linked(anchor)) begin
          if (cmd == CMD_INS_AFTER) begin
            left  = anchor;
            right = succ_tbl[anchor];
          end else begin
            left  = pred_tbl[anchor];
            right = anchor;
          end
          succ_tbl[node]  = right;
          pred_tbl[node]  = left;
          succ_tbl[left]  = node;
          pred_tbl[right] = node;
          member[node]    = 1'b1;
          live_nodes.push_back(node);
          rsp.status = STATUS_DONE;
        end
      end
      CMD_DELETE: begin
        if (node != '0 && member[node]) begin
          left  = pred_tbl[node];
          right = succ_tbl[node];
          succ_tbl[left]  = right;
          pred_tbl[right] = left;
          succ_tbl[node]  = '0;
          pred_tbl[node]  = '0;
          member[node]    = 1'b0;
          foreach (live_nodes[i]) begin
            if (live_nodes[i] == node) begin
              live_nodes.delete(i);
              break;
            end
          end
          rsp.status = STATUS_DONE;
        end
      end
      default: rsp.status = STATUS_DONE;
    endcase
    if (is_linked(node)) begin
      rsp.next_node    = succ_tbl[node];
      rsp.prev_node    = pred_tbl[node];
      rsp.node_present = 1'b1;
    end else begin
      rsp.next_node    = '0;
      rsp.prev_node    = '0;
      rsp.node_present = 1'b0;
    end
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                              input logic [NODE_W-1:0] anchor);
    link_rsp_t want;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= cmd;
    cmd_bus.node    <= node;
    cmd_bus.anchor  <= anchor;
    do @(posedge clk); while (!cmd_bus.ready);
    model_command(cmd, node, anchor, want);
    pending_rsp.push_back(want);
  endtask

  always @(negedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result expected none actual status %0d next %0d prev %0d pres %0d",
                 $time, rsp_bus.status, rsp_bus.next_node, rsp_bus.prev_node,
                 rsp_bus.node_present);
        mismatch_count++;
      end else begin
        report_field("status", pending_rsp[0].status, rsp_bus.status);
        report_field("next_node", pending_rsp[0].next_node, rsp_bus.next_node);
        report_field("prev_node", pending_rsp[0].prev_node, rsp_bus.prev_node);
        report_field("node_present", pending_rsp[0].node_present, rsp_bus.node_present);
        void'(pending_rsp.pop_front());
      end
    end
  end

  function automatic logic [NODE_W-1:0] pick_absent();
    logic [NODE_W-1:0] n;
    do n = NODE_W'($urandom_range(NODE_COUNT - 1, 1)); while (member[n]);
    return n;
  endfunction

  function automatic logic [NODE_W-1:0] pick_live();
    if (live_nodes.size() == 0) return '0;
    return NODE_W'(live_nodes[$urandom_range(live_nodes.size() - 1)]);
  endfunction

  task automatic test_empty_list();
    send_command(CMD_READ, 10'd0, 10'd0);
    send_command(CMD_DELETE, 10'd0, 10'd0);
    send_command(CMD_DELETE, 10'd5, 10'd1023);
    send_command(CMD_INS_AFTER, 10'd0, 10'd0);
    send_command(CMD_INS_AFTER, 10'd7, 10'd9);
    send_command(CMD_READ, 10'd1023, 10'd1023);
  endtask

  task automatic test_insert_after();
    send_command(CMD_INS_AFTER, 10'd1023, 10'd0);
    send_command(CMD_INS_AFTER, 10'd1, 10'd1023);
    send_command(CMD_INS_AFTER, 10'd512, 10'd0);
    send_command(CMD_READ, 10'd0, 10'd0);
    send_command(CMD_READ, 10'd1023, 10'd0);
  endtask

  task automatic test_insert_before();
    send_command(CMD_INS_BEFORE, 10'd341, 10'd0);
    send_command(CMD_INS_BEFORE, 10'd682, 10'd1);
    send_command(CMD_INS_BEFORE, 10'd1, 10'd0);
    send_command(CMD_READ, 10'd682, 10'd0);
  endtask

  task automatic test_delete();
    send_command(CMD_DELETE, 10'd1023, 10'd0);
    send_command(CMD_DELETE, 10'd1023, 10'd0);
    send_command(CMD_DELETE, 10'd341, 10'd0);
    send_command(CMD_READ, 10'd512, 10'd0);
    send_command(CMD_READ, 10'd0, 10'd0);
    send_command(CMD_DELETE, 10'd1, 10'd0);
    send_command(CMD_DELETE, 10'd682, 10'd0);
    send_command(CMD_DELETE, 10'd512, 10'd0);
    send_command(CMD_READ, 10'd0, 10'd0);
  endtask

  task automatic test_random_traffic(input int beats, input int src_pct, input int sink_pct);
    int                roll;
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] anchor;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (beats) begin
      roll   = $urandom_range(99);
      anchor = NODE_W'($urandom_range(NODE_COUNT - 1));
      if (roll < 10) begin
        cmd  = CMD_W'($urandom_range(3));
        node = NODE_W'($urandom_range(NODE_COUNT - 1));
      end else if (live_nodes.size() == 0 || (roll < 45 && live_nodes.size() < 48)) begin
        cmd    = $urandom_range(1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
        node   = pick_absent();
        anchor = ($urandom_range(3) == 0) ? '0 : pick_live();
      end else if (roll < 70 || live_nodes.size() > 60) begin
        cmd  = CMD_DELETE;
        node = pick_live();
      end else if (roll < 85) begin
        cmd  = CMD_READ;
        node = ($urandom_range(7) == 0) ? '0 : pick_live();
      end else begin
        case ($urandom_range(2))
          0: begin
            cmd  = $urandom_range(1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
            node = pick_live();
          end
          1: begin
            cmd    = $urandom_range(1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
            node   = pick_absent();
            anchor = pick_absent();
          end
          default: begin
            cmd  = CMD_DELETE;
            node = pick_absent();
          end
        endcase
      end
      send_command(cmd, node, anchor);
    end
  endtask

  initial begin
    int drain_cycles;
    rst_n           = 1'b0;
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = CMD_READ;
    cmd_bus.node    = '0;
    cmd_bus.anchor  = '0;
    rsp_bus.ready   = 1'b0;
    foreach (member[i]) begin
      member[i]   = 1'b0;
      succ_tbl[i] = '0;
      pred_tbl[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_insert_after();
    test_insert_before();
    test_delete();
    test_random_traffic(115, 0, 0);
    test_random_traffic(110, 77, 0);
    test_random_traffic(110, 0, 77);
    test_random_traffic(115, 23, 23);

    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    drain_cycles = 0;
    while (pending_rsp.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (16) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d results expected actual none", $time, pending_rsp.size());
      mismatch_count += pending_rsp.size();
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/idll_pkg.sv
rtl/core/idll_if.sv
rtl/core/idll_ctrl.sv
rtl/core/idll_dpath.sv
rtl/core/indexed_doubly_linked_list_top.sv
rtl/core/idll_checker.sv
sim/testbench.sv
